[src/assert_macros.svh]
// assertion macros shared by the string escape decoder modules
// depends on nothing; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// expression must hold at every clock edge outside reset
`define SED_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define SED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the following cycle
`define SED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SED_ASSERT(lbl, clk, rst_n, expr)
`define SED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/sed_pkg.sv]
// shared types for the string escape decoder
// depends on nothing; imported by sed_core, sed_fifo and the top level
package sed_pkg;

    // one decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic       closed_by_quote;
    } t_result;

    // results produced by one source byte, num is 0, 1 or 2
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

[src/sed_core.sv]
// input register, escape state and per-byte decode logic
// depends on sed_pkg and assert_macros.svh
`include "assert_macros.svh"
module sed_core
    import sed_pkg::*;
#(
    parameter int CNT_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_source_end,
    input  logic [CNT_W-1:0] i_free,
    output t_push            o_push
);

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX,
        MODE_OCT
    } t_mode;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_XL    = 8'h78;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_AL    = 8'h61;
    localparam logic [7:0] CH_FL    = 8'h66;
    localparam logic [7:0] CH_AU    = 8'h41;
    localparam logic [7:0] CH_FU    = 8'h46;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_end;
    t_mode      r_mode;
    logic [8:0] r_val;
    logic [1:0] r_cnt;

    t_mode      n_mode;
    logic [8:0] n_val;
    logic [1:0] n_cnt;

    logic       is_end;
    logic       is_hex;
    logic [3:0] hex_d;
    logic       is_oct;
    logic [8:0] hex_sum;
    logic [8:0] oct_sum;
    logic [1:0] cnt_inc;
    logic       do_plain;
    t_result    plain_res;
    logic       plain_emit;
    t_push      push;

    // hex digit classification of the registered byte
    always_comb begin
        is_hex = 1'b1;
        hex_d  = 4'd0;
        if (r_s1_byte >= CH_0 && r_s1_byte <= CH_9) begin
            hex_d = r_s1_byte[3:0];
        end else if ((r_s1_byte >= CH_AL && r_s1_byte <= CH_FL) ||
                     (r_s1_byte >= CH_AU && r_s1_byte <= CH_FU)) begin
            hex_d = r_s1_byte[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign is_end  = r_s1_end || (r_s1_byte == 8'h00);
    assign is_oct  = (r_s1_byte >= CH_0) && (r_s1_byte <= CH_7);
    assign hex_sum = {r_val[4:0], hex_d};
    assign oct_sum = {r_val[5:0], r_s1_byte[2:0]};
    assign cnt_inc = r_cnt + 2'd1;

    always_comb begin
        n_mode     = r_mode;
        n_val      = r_val;
        n_cnt      = r_cnt;
        push       = '0;
        do_plain   = 1'b0;
        plain_res  = '0;
        plain_emit = 1'b0;

        unique case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_PLAIN;
                if (is_end) begin
                    // dangling backslash gives a nul byte, then the string ends
                    push.res0.byte_valid = 1'b1;
                    push.num             = 2'd1;
                    do_plain             = 1'b1;
                end else if (r_s1_byte == CH_N) begin
                    push.res0 = '{CH_LF, 1'b1, 1'b0, 1'b0};
                    push.num  = 2'd1;
                end else if (r_s1_byte == CH_T) begin
                    push.res0 = '{CH_TAB, 1'b1, 1'b0, 1'b0};
                    push.num  = 2'd1;
                end else if (r_s1_byte == CH_R) begin
                    push.res0 = '{CH_CR, 1'b1, 1'b0, 1'b0};
                    push.num  = 2'd1;
                end else if (r_s1_byte == CH_E) begin
                    push.res0 = '{CH_ESC, 1'b1, 1'b0, 1'b0};
                    push.num  = 2'd1;
                end else if (r_s1_byte == CH_XL || r_s1_byte == CH_XU) begin
                    n_mode = MODE_HEX;
                    n_val  = '0;
                    n_cnt  = '0;
                end else if (is_oct) begin
                    n_mode = MODE_OCT;
                    n_val  = {6'd0, r_s1_byte[2:0]};
                    n_cnt  = 2'd1;
                end else begin
                    push.res0 = '{r_s1_byte, 1'b1, 1'b0, 1'b0};
                    push.num  = 2'd1;
                end
            end
            MODE_HEX: begin
                if (!is_end && is_hex) begin
                    if (cnt_inc >= 2'd2) begin
                        push.res0 = '{hex_sum[7:0], 1'b1, 1'b0, 1'b0};
                        push.num  = 2'd1;
                        n_mode    = MODE_PLAIN;
                        n_val     = '0;
                        n_cnt     = '0;
                    end else begin
                        n_val = hex_sum;
                        n_cnt = cnt_inc;
                    end
                end else begin
                    // no digits after x gives a literal lowercase x
                    push.res0 = '{(r_cnt == 2'd0) ? CH_XL : r_val[7:0], 1'b1, 1'b0, 1'b0};
                    push.num  = 2'd1;
                    n_mode    = MODE_PLAIN;
                    n_val     = '0;
                    n_cnt     = '0;
                    do_plain  = 1'b1;
                end
            end
            MODE_OCT: begin
                if (!is_end && is_oct) begin
                    if (cnt_inc == 2'd3 || cnt_inc == 2'd0) begin
                        push.res0 = '{oct_sum[7:0], 1'b1, 1'b0, 1'b0};
                        push.num  = 2'd1;
                        n_mode    = MODE_PLAIN;
                        n_val     = '0;
                        n_cnt     = '0;
                    end else begin
                        n_val = oct_sum;
                        n_cnt = cnt_inc;
                    end
                end else begin
                    push.res0 = '{r_val[7:0], 1'b1, 1'b0, 1'b0};
                    push.num  = 2'd1;
                    n_mode    = MODE_PLAIN;
                    n_val     = '0;
                    n_cnt     = '0;
                    do_plain  = 1'b1;
                end
            end
            MODE_PLAIN: begin
                do_plain = 1'b1;
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase

        if (do_plain) begin
            if (is_end) begin
                plain_res  = '{8'h00, 1'b0, 1'b1, 1'b0};
                plain_emit = 1'b1;
                n_mode     = MODE_PLAIN;
                n_val      = '0;
                n_cnt      = '0;
            end else if (r_s1_byte == CH_QUOTE) begin
                plain_res  = '{8'h00, 1'b0, 1'b1, 1'b1};
                plain_emit = 1'b1;
                n_mode     = MODE_PLAIN;
                n_val      = '0;
                n_cnt      = '0;
            end else if (r_s1_byte == CH_BSL) begin
                n_mode = MODE_ESC;
                n_val  = '0;
                n_cnt  = '0;
            end else begin
                plain_res  = '{r_s1_byte, 1'b1, 1'b0, 1'b0};
                plain_emit = 1'b1;
            end
            if (plain_emit) begin
                if (push.num == 2'd0) begin
                    push.res0 = plain_res;
                end else begin
                    push.res1 = plain_res;
                end
                push.num = push.num + 2'd1;
            end
        end

        if (!r_s1_valid) begin
            push   = '0;
            n_mode = r_mode;
            n_val  = r_val;
            n_cnt  = r_cnt;
        end
    end

    assign o_push = push;
    // room must remain for the pending push plus a worst case item behind it
    assign o_ready = (i_free >= (CNT_W'(push.num) + CNT_W'(2)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_mode     <= MODE_PLAIN;
            r_val      <= '0;
            r_cnt      <= '0;
        end else begin
            r_s1_valid <= i_valid && o_ready;
            r_mode     <= n_mode;
            r_val      <= n_val;
            r_cnt      <= n_cnt;
        end
        if (i_valid && o_ready) begin
            r_s1_byte <= i_in_byte;
            r_s1_end  <= i_source_end;
        end
    end

    `SED_ASSERT_IMPL(a_done_no_byte, i_clk, i_rst_n, push.num != 2'd0 && push.res0.string_done, !push.res0.byte_valid)
    `SED_ASSERT_IMPL(a_pair_leads_byte, i_clk, i_rst_n, push.num == 2'd2, push.res0.byte_valid && !push.res0.string_done)
    `SED_ASSERT_NEXT(a_end_resets_mode, i_clk, i_rst_n, push.num == 2'd2 && push.res1.string_done, r_mode == MODE_PLAIN && r_cnt == 2'd0)

endmodule

[src/sed_fifo.sv]
// result queue taking up to two results per cycle and giving one per transfer
// depends on sed_pkg and assert_macros.svh
`include "assert_macros.svh"
module sed_fifo
    import sed_pkg::*;
#(
    parameter int DEPTH = 4,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    output logic [CNT_W-1:0] o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output t_result          o_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;

    logic [PTR_W-1:0] tail1;
    logic [PTR_W-1:0] tail2;
    logic [PTR_W-1:0] head1;
    logic             pop;

    assign pop   = o_valid && i_ready;
    assign tail1 = (r_tail == LAST) ? '0 : r_tail + 1'b1;
    assign tail2 = (tail1 == LAST) ? '0 : tail1 + 1'b1;
    assign head1 = (r_head == LAST) ? '0 : r_head + 1'b1;

    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_head];
    assign o_free  = CNT_W'(DEPTH) - r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (pop) begin
                r_head <= head1;
            end
            if (i_push.num == 2'd1) begin
                r_tail <= tail1;
            end else if (i_push.num == 2'd2) begin
                r_tail <= tail2;
            end
            r_count <= r_count + CNT_W'(i_push.num) - CNT_W'(pop);
        end
        if (i_push.num != 2'd0) begin
            r_mem[r_tail] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[tail1] <= i_push.res1;
        end
    end

    `SED_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `SED_ASSERT(a_no_overflow, i_clk, i_rst_n, CNT_W'(i_push.num) <= o_free + CNT_W'(pop))
    `SED_ASSERT_IMPL(a_full_valid, i_clk, i_rst_n, o_free == '0, o_valid)

endmodule

[src/string_escape_decoder.sv]
// top level of the string escape decoder
// depends on sed_pkg, sed_core and sed_fifo
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  source   | i_valid / o_ready  | i_in_byte, i_source_end
//  result   | o_valid / i_ready  | o_out_byte, o_byte_valid, o_string_done,
//           |                    | o_closed_by_quote
//
//  one source byte per cycle while o_ready is high; a byte is decoded in the
//  cycle after its transfer, when its results are pushed into the result queue
//  the result port moves one result per transfer, so a byte that gives two
//  results occupies it for two transfers; the result queue of FIFO_DEPTH entries
//  absorbs that and stalls on the result side
//  o_ready drops when the queue cannot hold the pending results plus two more
//  synchronous active-low reset returns the decoder to plain text and empties
//  the queue
module string_escape_decoder
    import sed_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // source channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_source_end,
    // result channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_string_done,
    output logic       o_closed_by_quote
);

    // queue must hold a full pair in flight plus a pair being decoded
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_push            push;
    logic [CNT_W-1:0] free;
    t_result          res;

    // input register and escape decoding
    sed_core #(
        .CNT_W (CNT_W)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_source_end (i_source_end),
        .i_free       (free),
        .o_push       (push)
    );

    // result queue, one transfer out per cycle while results wait and i_ready is high
    sed_fifo #(
        .DEPTH (FIFO_DEPTH),
        .CNT_W (CNT_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_out_byte        = res.out_byte;
    assign o_byte_valid      = res.byte_valid;
    assign o_string_done     = res.string_done;
    assign o_closed_by_quote = res.closed_by_quote;

endmodule
